/* sv/iib_pkg.sv */
// Shared types and fixed widths for the integral image builder.
// No dependencies; imported by every module of the block.
package iib_pkg;

    localparam int SUM_W   = 20;
    localparam int CFG_W   = 7;
    localparam int GRAY_W  = 8;
    localparam int COORD_W = 8;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic is_read;
        logic oor;
        logic done;
        logic use_up;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

/* sv/iib_front.sv */
// Front end: configuration registers, raster counters and row running sum.
// Classifies each beat into a queue entry; depends on iib_pkg.
module iib_front
    import iib_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int ADDR_W     = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [REG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_push,
    input  logic                      i_kind,
    input  logic [GRAY_W-1:0]         i_gray,
    input  logic signed [COORD_W-1:0] i_read_x,
    input  logic signed [COORD_W-1:0] i_read_y,
    output t_ctl                      o_ctl,
    output logic [ADDR_W-1:0]         o_rd_addr,
    output logic [ADDR_W-1:0]         o_wr_addr,
    output logic [SUM_W-1:0]          o_rsum
);

    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W = ((XW > YW ? XW : YW) > CFG_W ? (XW > YW ? XW : YW) : CFG_W) + 1;

    function automatic logic [CFG_W-1:0] limit_size(input logic [CFG_W-1:0] v,
                                                    input int maxv);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > maxv) begin
            r = CFG_W'(maxv);
        end
        return r;
    endfunction

    logic [CFG_W-1:0] r_fw, n_fw;
    logic [CFG_W-1:0] r_fh, n_fh;
    logic [XW-1:0]    r_col, n_col;
    logic [YW-1:0]    r_row, n_row;
    logic [SUM_W-1:0] r_rsum, n_rsum;

    logic [SUM_W-1:0]  rsum_add;
    logic [CMP_W-1:0]  col_inc;
    logic [CMP_W-1:0]  row_inc;
    logic              last_col;
    logic              last_row;
    logic [ADDR_W-1:0] own_addr;
    logic [CFG_W-1:0]  rx_mag;
    logic [CFG_W-1:0]  ry_mag;
    logic              read_oor;

    assign rsum_add = r_rsum + SUM_W'(i_gray);
    assign col_inc  = CMP_W'(r_col) + CMP_W'(1);
    assign row_inc  = CMP_W'(r_row) + CMP_W'(1);
    assign last_col = (col_inc == CMP_W'(r_fw));
    assign last_row = (row_inc == CMP_W'(r_fh));
    assign own_addr = ADDR_W'(r_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_col);
    assign rx_mag   = i_read_x[CFG_W-1:0];
    assign ry_mag   = i_read_y[CFG_W-1:0];
    assign read_oor = i_read_x[COORD_W-1] | i_read_y[COORD_W-1] |
                      (rx_mag >= r_fw) | (ry_mag >= r_fh);

    always_comb begin
        o_ctl.is_read = i_kind;
        o_ctl.oor     = i_kind & read_oor;
        o_ctl.done    = ~i_kind & last_col & last_row;
        o_ctl.use_up  = ~i_kind & (r_row != '0);
        o_rsum        = rsum_add;
        if (i_kind) begin
            o_rd_addr = ADDR_W'(ry_mag) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx_mag);
            o_wr_addr = '0;
        end else begin
            o_rd_addr = own_addr - ADDR_W'(MAX_WIDTH);
            o_wr_addr = own_addr;
        end
    end

    always_comb begin
        n_fw   = r_fw;
        n_fh   = r_fh;
        n_col  = r_col;
        n_row  = r_row;
        n_rsum = r_rsum;
        if (i_cfg_we) begin
            n_col  = '0;
            n_row  = '0;
            n_rsum = '0;
            case (i_cfg_index)
                REG_FRAME_WIDTH:  n_fw = limit_size(i_cfg_data, MAX_WIDTH);
                REG_FRAME_HEIGHT: n_fh = limit_size(i_cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end else if (i_push && !i_kind) begin
            if (last_col) begin
                n_col  = '0;
                n_rsum = '0;
                n_row  = last_row ? '0 : YW'(row_inc);
            end else begin
                n_col  = XW'(col_inc);
                n_rsum = rsum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= limit_size(CFG_W'(64), MAX_WIDTH);
            r_fh   <= limit_size(CFG_W'(64), MAX_HEIGHT);
            r_col  <= '0;
            r_row  <= '0;
            r_rsum <= '0;
        end else begin
            r_fw   <= n_fw;
            r_fh   <= n_fh;
            r_col  <= n_col;
            r_row  <= n_row;
            r_rsum <= n_rsum;
        end
    end

endmodule

/* sv/iib_queue.sv */
// Small FIFO between the front end and the back end.
// Generic payload width; depends on iib_pkg only by convention.
module iib_queue
    import iib_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_cnt, n_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/iib_back.sv */
// Back end: frame store, sum formation and output register; uses iib_pkg.
// Reads the entry above or the requested one, then writes pixel sums and returns.
module iib_back
    import iib_pkg::*;
#(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_ctl              i_ctl,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SUM_W-1:0]  i_rsum,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [SUM_W-1:0]  o_sum_value,
    output logic              o_off_frame,
    output logic              o_frame_done
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    logic [SUM_W-1:0]  r_store [DEPTH];
    logic [SUM_W-1:0]  r_rdata;

    t_state            r_state, n_state;
    t_ctl              r_ctl;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [SUM_W-1:0]  r_rsum;

    logic              r_out_valid, n_out_valid;
    logic [SUM_W-1:0]  r_sum;
    logic              r_oor;
    logic              r_done;

    logic              can_load;
    logic              load;
    logic              wr_en;
    logic [SUM_W-1:0]  sum_calc;

    assign can_load = !r_out_valid || !i_out_stall;
    assign load     = (r_state == ST_CALC) && can_load;
    assign wr_en    = load && !r_ctl.is_read;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        if (r_ctl.is_read) begin
            sum_calc = r_ctl.oor ? '0 : r_rdata;
        end else begin
            sum_calc = r_rsum + (r_ctl.use_up ? r_rdata : '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (can_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_addr] <= sum_calc;
        end
        if (o_pop) begin
            r_rdata <= r_store[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl     <= i_ctl;
            r_wr_addr <= i_wr_addr;
            r_rsum    <= i_rsum;
        end
        if (load) begin
            r_sum  <= sum_calc;
            r_oor  <= r_ctl.oor;
            r_done <= r_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sum_value  = r_sum;
    assign o_off_frame  = r_oor;
    assign o_frame_done = r_done;

endmodule

/* sv/integral_image_builder.sv */
// Integral image builder: summed-area table over raster-order gray pixels.
// Instantiates iib_front, iib_queue and iib_back; uses iib_pkg.
//
// Input channel (i_in_valid / o_in_stall): one beat per item. i_kind = 0 is a
// pixel (i_gray), i_kind = 1 reads the stored sum at (i_read_x, i_read_y).
// Output channel (o_out_valid / i_out_stall): one beat per item, in order.
// A pixel returns its sum from the frame origin and o_frame_done on the last
// pixel of a frame; a read returns the stored sum, or zero with
// o_off_frame when outside frame_width x frame_height.
// Configuration: i_cfg_we writes frame_width (index 0) or frame_height
// (index 1); either write restarts the frame at the origin.
// Each item passes the queue, the store read register and output register.
// The back end pops a new item only once the last is done: the frame store
// reads the entry above, then the new sum is written; stalls hold ST_CALC.
// Reset: counters and running sum clear, sizes return to 64 (capped at the
// maximum); the frame store is not cleared. A stalled result holds in the
// output register while a 2-entry queue keeps taking input beats until full.
module integral_image_builder
    import iib_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [REG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [GRAY_W-1:0]         i_gray,
    input  logic signed [COORD_W-1:0] i_read_x,
    input  logic signed [COORD_W-1:0] i_read_y,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SUM_W-1:0]          o_sum_value,
    output logic                      o_off_frame,
    output logic                      o_frame_done
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int Q_W    = CTL_W + 2 * ADDR_W + SUM_W;

    t_ctl              f_ctl;
    logic [ADDR_W-1:0] f_rd_addr;
    logic [ADDR_W-1:0] f_wr_addr;
    logic [SUM_W-1:0]  f_rsum;

    t_ctl              b_ctl;
    logic [ADDR_W-1:0] b_rd_addr;
    logic [ADDR_W-1:0] b_wr_addr;
    logic [SUM_W-1:0]  b_rsum;

    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              push;
    logic [Q_W-1:0]    q_out;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    iib_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_kind      (i_kind),
        .i_gray      (i_gray),
        .i_read_x    (i_read_x),
        .i_read_y    (i_read_y),
        .o_ctl       (f_ctl),
        .o_rd_addr   (f_rd_addr),
        .o_wr_addr   (f_wr_addr),
        .o_rsum      (f_rsum)
    );

    iib_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_rd_addr, f_wr_addr, f_rsum}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_ctl, b_rd_addr, b_wr_addr, b_rsum} = q_out;

    iib_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_ctl        (b_ctl),
        .i_rd_addr    (b_rd_addr),
        .i_wr_addr    (b_wr_addr),
        .i_rsum       (b_rsum),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sum_value  (o_sum_value),
        .o_off_frame  (o_off_frame),
        .o_frame_done (o_frame_done)
    );

endmodule

/* tb/sv/integral_image_builder_tb.sv */
// Self-checking testbench for integral_image_builder: directed table, then random pixel/read
// phases, most under random idle and stall; each result beat is checked against a local
// model or the directed row's expected value; depends on iib_pkg and integral_image_builder.
module integral_image_builder_tb;
    import iib_pkg::*;

    localparam int MAXW = 64;
    localparam int MAXH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             oor;
        logic             done;
    } t_sat_beat;

    typedef enum logic [1:0] {ROW_SIZE, ROW_PIXEL, ROW_READ} t_row_op;

    typedef struct packed {
        t_row_op op;
        int      p0;
        int      p1;
        logic    chk;
        int      e_sum;
        logic    e_oor;
        logic    e_done;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [26] = '{
        '{ROW_SIZE,    0,    2, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL, 255,    0, 1'b1, 255, 1'b0, 1'b0},
        '{ROW_PIXEL, 255,    0, 1'b1, 510, 1'b0, 1'b1},
        '{ROW_READ,    0,    1, 1'b1, 510, 1'b0, 1'b0},
        '{ROW_READ,    1,    0, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_READ, -128,    0, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_READ,    0,  127, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_READ,   -1,   -1, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_SIZE,  127,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL,   0,    0, 1'b1,   0, 1'b0, 1'b0},
        '{ROW_PIXEL, 255,    0, 1'b1, 255, 1'b0, 1'b0},
        '{ROW_PIXEL, 170,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_READ,    0,    0, 1'b1,   0, 1'b0, 1'b0},
        '{ROW_READ,    1,    0, 1'b1, 255, 1'b0, 1'b0},
        '{ROW_READ,    2,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_READ,   64,    0, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_READ,    0,    1, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_SIZE,    2,   64, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL,  85,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_READ,    0,    1, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL,   1,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL,   2,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_PIXEL,   3,    0, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_READ,    1,    1, 1'b0,   0, 1'b0, 1'b0},
        '{ROW_READ,    2,    0, 1'b1,   0, 1'b1, 1'b0},
        '{ROW_READ,  127, -128, 1'b1,   0, 1'b1, 1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_kind = KIND_PIXEL;
    logic [GRAY_W-1:0]    i_gray = '0;
    logic [COORD_W-1:0]   i_read_x = '0;
    logic [COORD_W-1:0]   i_read_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [SUM_W-1:0]     o_sum_value;
    logic                 o_off_frame;
    logic                 o_frame_done;

    logic [SUM_W-1:0] sat_mem [MAXW*MAXH];
    bit               written_mem [MAXW*MAXH];
    logic [SUM_W-1:0] row_acc = '0;
    int               col_pos = 0;
    int               row_pos = 0;
    int               frame_w = 64;
    int               frame_h = 64;

    t_sat_beat pending_sums [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        idling = 1'b1;

    integral_image_builder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_gray       (i_gray),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sum_value  (o_sum_value),
        .o_off_frame  (o_off_frame),
        .o_frame_done (o_frame_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
        if (v == '0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(65, 127));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic t_sat_beat predict_sum(logic kind, logic [GRAY_W-1:0] gray,
                                              logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry);
        t_sat_beat        r;
        logic [SUM_W-1:0] above;
        int               xi;
        int               yi;
        r = '0;
        if (kind == KIND_PIXEL) begin
            above = '0;
            row_acc = row_acc + gray;
            if (row_pos > 0) above = sat_mem[(row_pos - 1) * MAXW + col_pos];
            r.sum = row_acc + above;
            sat_mem[row_pos * MAXW + col_pos] = r.sum;
            written_mem[row_pos * MAXW + col_pos] = 1'b1;
            col_pos++;
            if (col_pos >= frame_w) begin
                col_pos = 0;
                row_acc = '0;
                row_pos++;
                if (row_pos >= frame_h) begin
                    row_pos = 0;
                    r.done = 1'b1;
                end
            end
        end else begin
            xi = $signed(rx);
            yi = $signed(ry);
            if (xi < 0 || yi < 0 || xi >= frame_w || yi >= frame_h) r.oor = 1'b1;
            else r.sum = sat_mem[yi * MAXW + xi];
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatch_count < 40) $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic feed_beat(logic kind, logic [GRAY_W-1:0] gray, logic [COORD_W-1:0] rx,
                             logic [COORD_W-1:0] ry, logic typed, t_sat_beat typed_beat);
        t_sat_beat want;
        if (idling) begin
            while ($urandom_range(0, 99) < 33) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_gray     <= gray;
        i_read_x   <= rx;
        i_read_y   <= ry;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = predict_sum(kind, gray, rx, ry);
        if (typed) want = typed_beat;
        pending_sums.push_back(want);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_w = clamp_size(w, MAXW);
        frame_h = clamp_size(h, MAXH);
        row_acc = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= idling && ($urandom_range(0, 99) < 33);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sat_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sums.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing pending, sum %0d",
                                        o_sum_value));
            end else begin
                want = pending_sums.pop_front();
                if (o_sum_value !== want.sum)
                    flag_mismatch($sformatf("sum_value got %0d want %0d",
                                            o_sum_value, want.sum));
                if (o_off_frame !== want.oor)
                    flag_mismatch($sformatf("off_frame got %0b want %0b",
                                            o_off_frame, want.oor));
                if (o_frame_done !== want.done)
                    flag_mismatch($sformatf("frame_done got %0b want %0b",
                                            o_frame_done, want.done));
            end
        end
    end

    initial begin
        t_stim_row          row;
        t_sat_beat          typed_beat;
        t_sat_beat          no_beat;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [CFG_W-1:0]   w;
        logic [CFG_W-1:0]   h;
        int                 xi;
        int                 yi;

        no_beat = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            typed_beat.sum  = row.e_sum[SUM_W-1:0];
            typed_beat.oor  = row.e_oor;
            typed_beat.done = row.e_done;
            case (row.op)
                ROW_SIZE: begin
                    drain_results();
                    set_frame(row.p0[CFG_W-1:0], row.p1[CFG_W-1:0]);
                end
                ROW_PIXEL: feed_beat(KIND_PIXEL, row.p0[GRAY_W-1:0], '0, '0,
                                     row.chk, typed_beat);
                default: feed_beat(KIND_READ, '0, row.p0[COORD_W-1:0], row.p1[COORD_W-1:0],
                                   row.chk, typed_beat);
            endcase
        end

        for (int ph = 0; ph < 6; ph++) begin
            w = pick_size();
            h = pick_size();
            if (ph == 1) w = CFG_W'(MAXW);
            drain_results();
            set_frame(w, h);
            idling = (ph != 3);
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(0, 99) < 2) drain_results();
                if ($urandom_range(0, 99) < 70) begin
                    feed_beat(KIND_PIXEL, GRAY_W'($urandom), COORD_W'($urandom),
                              COORD_W'($urandom), 1'b0, no_beat);
                end else begin
                    if ($urandom_range(0, 99) < 60) begin
                        rx = COORD_W'($urandom_range(0, frame_w - 1));
                        ry = COORD_W'($urandom_range(0, frame_h - 1));
                        for (int t = 0; t < 8 && !written_mem[ry * MAXW + rx]; t++) begin
                            rx = COORD_W'($urandom_range(0, frame_w - 1));
                            ry = COORD_W'($urandom_range(0, frame_h - 1));
                        end
                    end else begin
                        rx = COORD_W'($urandom);
                        ry = COORD_W'($urandom);
                    end
                    xi = $signed(rx);
                    yi = $signed(ry);
                    // push reads of never-written entries out of the frame
                    if (xi >= 0 && yi >= 0 && xi < frame_w && yi < frame_h &&
                        !written_mem[yi * MAXW + xi])
                        rx[COORD_W-1] = 1'b1;
                    feed_beat(KIND_READ, GRAY_W'($urandom), rx, ry, 1'b0, no_beat);
                end
            end
        end

        idling = 1'b1;
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* integral_image_builder.f */
sv/iib_pkg.sv
sv/iib_front.sv
sv/iib_queue.sv
sv/iib_back.sv
sv/integral_image_builder.sv
tb/sv/integral_image_builder_tb.sv
